[rtl/dcmo_pkg.sv]
// Shared constants, types and the microcode table of the DC motor current observer.
`timescale 1ns / 1ps

package dcmo_pkg;

   localparam int SAMPLE_WIDTH = 16;

   localparam int EST_W      = 16;
   localparam int LIM_W      = 15;
   localparam int DZ_W       = 15;
   localparam int Q12_W      = 16;
   localparam int Q24_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int MA_W    = 24;
   localparam int MB_BASE = (SAMPLE_WIDTH > EST_W) ? SAMPLE_WIDTH : EST_W;
   localparam int MB_W    = (MB_BASE > Q24_W + 1) ? MB_BASE : Q24_W + 1;
   localparam int MP_W    = MA_W + MB_W;
   localparam int ACC_W   = 64;
   localparam int DIFF_W  = 40;
   localparam int HALF_W  = 20;
   localparam int GT_W    = 40;
   localparam int PRED_W  = 40;
   localparam int SUM_W   = PRED_W + 1;
   localparam int ERR_W   = 24;
   localparam int STEP_W  = 4;

   localparam int V_SHIFT       = 14;
   localparam int EMF_SHIFT     = 4;
   localparam int DIFF_CLAMP_SH = 38;
   localparam int ERR_CLAMP_SH  = 22;
   localparam int PRED_SHIFT    = 28;
   localparam int FIX_SHIFT     = 32;

   localparam logic [STEP_W-1:0] STEP_FINISH = STEP_W'(12);

   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_EMF_CONST  = 3'd0,
      REG_RESISTANCE = 3'd1,
      REG_DT_OVER_L  = 3'd2,
      REG_TIME_STEP  = 3'd3,
      REG_GAIN       = 3'd4,
      REG_DEAD_ZONE  = 3'd5,
      REG_LIMIT      = 3'd6
   } csr_reg_type;

   localparam logic [Q12_W-1:0] RST_EMF_CONST  = 16'd0;
   localparam logic [Q12_W-1:0] RST_RESISTANCE = 16'd0;
   localparam logic [Q24_W-1:0] RST_DT_OVER_L  = 24'd0;
   localparam logic [Q24_W-1:0] RST_TIME_STEP  = 24'd16777;
   localparam logic [Q12_W-1:0] RST_GAIN       = 16'd256;
   localparam logic [DZ_W-1:0]  RST_DEAD_ZONE  = 15'd26;
   localparam logic [LIM_W-1:0] RST_LIMIT      = 15'd20480;

   typedef struct packed {
      logic [Q12_W-1:0] emf_const;
      logic [Q12_W-1:0] resistance;
      logic [Q24_W-1:0] dt_over_l;
      logic [Q24_W-1:0] time_step;
      logic [Q12_W-1:0] gain;
      logic [DZ_W-1:0]  dead_zone;
      logic [LIM_W-1:0] limit;
   } cfg_type;

   typedef enum logic [2:0] {
      MA_RES, MA_KE, MA_GAIN, MA_DHI, MA_DLO, MA_ERR
   } mul_a_sel_type;

   typedef enum logic [2:0] {
      MB_EST, MB_SPEED, MB_TSTEP, MB_DTL, MB_GTHI, MB_GTLO
   } mul_b_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD, ACC_LOAD_V, ACC_SUB_P, ACC_SUB_P4, ACC_LOAD_P20, ACC_ADD_P
   } acc_op_type;

   typedef struct packed {
      mul_a_sel_type     ma;
      mul_b_sel_type     mb;
      acc_op_type        acc;
      logic              ld_diff;
      logic              ld_gt;
      logic              ld_pred;
      logic              ld_err;
      logic              ld_est;
      logic              jmp_clear;
      logic              last;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic      exec;
      ucode_type uc;
   } seq_ctrl_type;

   typedef struct packed {
      logic clear;
      logic out_free;
   } dp_status_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] addr);
      ucode_type uc;
      uc = '0;
      case (addr)
         4'd0: begin
            uc.ma = MA_RES; uc.mb = MB_EST; uc.acc = ACC_LOAD_V;
            uc.jmp_clear = 1'b1; uc.target = STEP_FINISH;
         end
         4'd1: begin
            uc.ma = MA_KE; uc.mb = MB_SPEED; uc.acc = ACC_SUB_P;
         end
         4'd2: begin
            uc.ma = MA_GAIN; uc.mb = MB_TSTEP; uc.acc = ACC_SUB_P4;
         end
         4'd3: begin
            uc.ld_diff = 1'b1; uc.ld_gt = 1'b1;
         end
         4'd4: begin
            uc.ma = MA_DHI; uc.mb = MB_DTL;
         end
         4'd5: begin
            uc.ma = MA_DLO; uc.mb = MB_DTL; uc.acc = ACC_LOAD_P20;
         end
         4'd6: begin
            uc.acc = ACC_ADD_P;
         end
         4'd7: begin
            uc.ld_pred = 1'b1;
         end
         4'd8: begin
            uc.ld_err = 1'b1;
         end
         4'd9: begin
            uc.ma = MA_ERR; uc.mb = MB_GTHI;
         end
         4'd10: begin
            uc.ma = MA_ERR; uc.mb = MB_GTLO; uc.acc = ACC_LOAD_P20;
         end
         4'd11: begin
            uc.acc = ACC_ADD_P;
         end
         4'd12: begin
            uc.ld_est = 1'b1; uc.last = 1'b1;
         end
         default: begin
            uc.last = 1'b1;
         end
      endcase
      return uc;
   endfunction

endpackage

[rtl/dcmo_ifs.sv]
// Request, response and register write channel interfaces.
`timescale 1ns / 1ps

interface dcmo_req_if
   import dcmo_pkg::*;
();
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic signed [SAMPLE_WIDTH-1:0] volt_cmd;
   logic signed [SAMPLE_WIDTH-1:0] rotor_speed;
   logic signed [SAMPLE_WIDTH-1:0] sensed_current;

   modport source (output valid, command, volt_cmd, rotor_speed, sensed_current,
                   input ready);
   modport sink (input valid, command, volt_cmd, rotor_speed, sensed_current,
                 output ready);
endinterface

interface dcmo_rsp_if
   import dcmo_pkg::*;
();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] estimated_current;
   logic signed [SAMPLE_WIDTH-1:0] signed_current;
   logic                           in_dead_zone;

   modport source (output valid, estimated_current, signed_current, in_dead_zone,
                   input ready);
   modport sink (input valid, estimated_current, signed_current, in_dead_zone,
                 output ready);
endinterface

interface dcmo_csr_if
   import dcmo_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/dcmo_csr.sv]
// Configuration register file of the current observer.
`timescale 1ns / 1ps

module dcmo_csr
   import dcmo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dcmo_csr_if.sink    csr_chan,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_EMF_CONST:  cfg_in.emf_const  = csr_chan.data[Q12_W-1:0];
            REG_RESISTANCE: cfg_in.resistance = csr_chan.data[Q12_W-1:0];
            REG_DT_OVER_L:  cfg_in.dt_over_l  = csr_chan.data[Q24_W-1:0];
            REG_TIME_STEP:  cfg_in.time_step  = csr_chan.data[Q24_W-1:0];
            REG_GAIN:       cfg_in.gain       = csr_chan.data[Q12_W-1:0];
            REG_DEAD_ZONE:  cfg_in.dead_zone  = csr_chan.data[DZ_W-1:0];
            REG_LIMIT:      cfg_in.limit      = csr_chan.data[LIM_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.emf_const  <= RST_EMF_CONST;
         cfg_ff.resistance <= RST_RESISTANCE;
         cfg_ff.dt_over_l  <= RST_DT_OVER_L;
         cfg_ff.time_step  <= RST_TIME_STEP;
         cfg_ff.gain       <= RST_GAIN;
         cfg_ff.dead_zone  <= RST_DEAD_ZONE;
         cfg_ff.limit      <= RST_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/dcmo_sequencer.sv]
// Step counter and microcode fetch driving the observer datapath.
`timescale 1ns / 1ps

module dcmo_sequencer
   import dcmo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   output logic          req_ready,
   output logic          start,
   output seq_ctrl_type  ctrl
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   ucode_type         uc;
   logic              exec;

   assign uc        = ucode_rom(step_ff);
   assign req_ready = ~busy_ff;
   assign start     = req_valid & ~busy_ff;
   assign exec      = busy_ff & (~uc.last | status.out_free);
   assign ctrl.exec = exec;
   assign ctrl.uc   = uc;

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
      end else if (exec) begin
         if (uc.last) begin
            busy_in = 1'b0;
         end else if (uc.jmp_clear && status.clear) begin
            step_in = uc.target;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

endmodule

[rtl/dcmo_datapath.sv]
// Shared multiplier, accumulator and operand registers of the observer.
`timescale 1ns / 1ps

module dcmo_datapath
   import dcmo_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic                           start,
   input  logic                           req_command,
   input  logic signed [SAMPLE_WIDTH-1:0] req_voltage,
   input  logic signed [SAMPLE_WIDTH-1:0] req_speed,
   input  logic signed [SAMPLE_WIDTH-1:0] req_current,
   input  seq_ctrl_type                   ctrl,
   output dp_status_type                  status,
   dcmo_rsp_if.source                     rsp_chan
);

   localparam logic signed [ACC_W-1:0] DIFF_MAX  = ACC_W'(1) <<< DIFF_CLAMP_SH;
   localparam logic signed [SUM_W-1:0] ERR_MAX   = SUM_W'(1) <<< ERR_CLAMP_SH;
   localparam logic signed [ACC_W-1:0] PRED_HALF = ACC_W'(1) <<< (PRED_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] FIX_HALF  = ACC_W'(1) <<< (FIX_SHIFT - 1);
   localparam logic signed [SAMPLE_WIDTH:0] SMAX =
      (SAMPLE_WIDTH + 1)'((1 <<< (SAMPLE_WIDTH - 1)) - 1);

   logic                           cmd_ff;
   logic signed [SAMPLE_WIDTH-1:0] v_ff, w_ff, m_ff;
   logic signed [MP_W-1:0]         p_ff, p_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [DIFF_W-1:0]       d_ff, d_in;
   logic        [GT_W-1:0]         gt_ff;
   logic signed [PRED_W-1:0]       pred_ff, pred_in;
   logic signed [ERR_W-1:0]        err_ff, err_in;
   logic signed [EST_W-1:0]        est_ff, est_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_est_ff, rsp_corr_ff;
   logic                           rsp_dead_ff;

   logic signed [MA_W-1:0]         ma_val;
   logic signed [MB_W-1:0]         mb_val;
   logic signed [ACC_W-1:0]        p_ext;
   logic signed [ACC_W-1:0]        rnd_pred, rnd_fix;
   logic signed [SUM_W-1:0]        e_raw, sum, lim_s;
   logic signed [SAMPLE_WIDTH:0]   av, mag, v_ext, m_ext;
   logic signed [SAMPLE_WIDTH-1:0] corr;
   logic                           dead;
   logic                           finish;

   assign finish = ctrl.exec & ctrl.uc.last;

   always_comb begin
      case (ctrl.uc.ma)
         MA_RES:  ma_val = MA_W'($signed({1'b0, cfg.resistance}));
         MA_KE:   ma_val = MA_W'($signed({1'b0, cfg.emf_const}));
         MA_GAIN: ma_val = MA_W'($signed({1'b0, cfg.gain}));
         MA_DHI:  ma_val = MA_W'($signed(d_ff[DIFF_W-1:HALF_W]));
         MA_DLO:  ma_val = MA_W'($signed({1'b0, d_ff[HALF_W-1:0]}));
         MA_ERR:  ma_val = MA_W'(err_ff);
         default: ma_val = '0;
      endcase
      case (ctrl.uc.mb)
         MB_EST:   mb_val = MB_W'(est_ff);
         MB_SPEED: mb_val = MB_W'(w_ff);
         MB_TSTEP: mb_val = MB_W'($signed({1'b0, cfg.time_step}));
         MB_DTL:   mb_val = MB_W'($signed({1'b0, cfg.dt_over_l}));
         MB_GTHI:  mb_val = MB_W'($signed({1'b0, gt_ff[GT_W-1:HALF_W]}));
         MB_GTLO:  mb_val = MB_W'($signed({1'b0, gt_ff[HALF_W-1:0]}));
         default:  mb_val = '0;
      endcase
      p_in = MP_W'(ma_val) * MP_W'(mb_val);
   end

   always_comb begin
      p_ext = ACC_W'(p_ff);
      case (ctrl.uc.acc)
         ACC_HOLD:     acc_in = acc_ff;
         ACC_LOAD_V:   acc_in = ACC_W'(v_ff) <<< V_SHIFT;
         ACC_SUB_P:    acc_in = acc_ff - p_ext;
         ACC_SUB_P4:   acc_in = acc_ff - (p_ext <<< EMF_SHIFT);
         ACC_LOAD_P20: acc_in = p_ext <<< HALF_W;
         ACC_ADD_P:    acc_in = acc_ff + p_ext;
         default:      acc_in = acc_ff;
      endcase
   end

   always_comb begin
      if (acc_ff > DIFF_MAX) begin
         d_in = DIFF_W'(DIFF_MAX);
      end else if (acc_ff < -DIFF_MAX) begin
         d_in = DIFF_W'(-DIFF_MAX);
      end else begin
         d_in = acc_ff[DIFF_W-1:0];
      end

      rnd_pred = (acc_ff + PRED_HALF) >>> PRED_SHIFT;
      pred_in  = PRED_W'(est_ff) + $signed(rnd_pred[PRED_W-1:0]);

      e_raw = SUM_W'(m_ff) - SUM_W'(pred_ff);
      if (e_raw > ERR_MAX) begin
         err_in = ERR_W'(ERR_MAX);
      end else if (e_raw < -ERR_MAX) begin
         err_in = ERR_W'(-ERR_MAX);
      end else begin
         err_in = e_raw[ERR_W-1:0];
      end

      rnd_fix = (acc_ff + FIX_HALF) >>> FIX_SHIFT;
      sum     = SUM_W'(pred_ff) + SUM_W'($signed(rnd_fix[PRED_W-1:0]));
      lim_s   = SUM_W'($signed({1'b0, cfg.limit}));
      if (cmd_ff == CMD_CLEAR) begin
         est_in = '0;
      end else if (sum > lim_s) begin
         est_in = EST_W'(lim_s);
      end else if (sum < -lim_s) begin
         est_in = EST_W'(-lim_s);
      end else begin
         est_in = sum[EST_W-1:0];
      end
   end

   always_comb begin
      v_ext = (SAMPLE_WIDTH + 1)'(v_ff);
      m_ext = (SAMPLE_WIDTH + 1)'(m_ff);
      av    = (v_ext < 0) ? -v_ext : v_ext;
      dead  = av < $signed({1'b0, cfg.dead_zone});
      mag   = (m_ext < 0) ? -m_ext : m_ext;
      if (mag > SMAX) begin
         mag = SMAX;
      end
      if (dead) begin
         corr = '0;
      end else if (v_ff >= 0) begin
         corr = mag[SAMPLE_WIDTH-1:0];
      end else begin
         corr = -mag[SAMPLE_WIDTH-1:0];
      end
   end

   assign rsp_valid_in = finish | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff <= req_command;
         v_ff   <= req_voltage;
         w_ff   <= req_speed;
         m_ff   <= req_current;
      end
      if (ctrl.exec) begin
         p_ff   <= p_in;
         acc_ff <= acc_in;
         if (ctrl.uc.ld_diff) begin
            d_ff <= d_in;
         end
         if (ctrl.uc.ld_gt) begin
            gt_ff <= p_ff[GT_W-1:0];
         end
         if (ctrl.uc.ld_pred) begin
            pred_ff <= pred_in;
         end
         if (ctrl.uc.ld_err) begin
            err_ff <= err_in;
         end
      end
      if (finish) begin
         rsp_est_ff  <= SAMPLE_WIDTH'(est_in);
         rsp_corr_ff <= corr;
         rsp_dead_ff <= dead;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.exec && ctrl.uc.ld_est) begin
            est_ff <= est_in;
         end
      end
   end

   assign status.clear    = (cmd_ff == CMD_CLEAR);
   assign status.out_free = ~rsp_valid_ff | rsp_chan.ready;

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.estimated_current = rsp_est_ff;
   assign rsp_chan.signed_current    = rsp_corr_ff;
   assign rsp_chan.in_dead_zone      = rsp_dead_ff;

endmodule

[rtl/dc_motor_current_observer_core.sv]
// Top level of the DC motor current observer.
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   command, volt_cmd, rotor_speed, sensed_current
//   rsp_chan  out  valid/ready   estimated_current, signed_current, in_dead_zone
//   csr_chan  in   valid/ready   index (3 bits), data (24 bits), always ready
//
// One request at a time: an observer step runs 13 microcode steps on the shared
// 24x25 multiplier and accumulator, a clear runs 2, and a new request is taken
// only once the last step of the one before has run. The result sits in an
// output register; the final step holds while that register is still full.
// Synchronous reset zeroes the estimate and loads the register defaults.
`timescale 1ns / 1ps

module dc_motor_current_observer_core
   import dcmo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dcmo_req_if.sink   req_chan,
   dcmo_rsp_if.source rsp_chan,
   dcmo_csr_if.sink   csr_chan
);

   cfg_type       cfg;
   seq_ctrl_type  ctrl;
   dp_status_type status;
   logic          start;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   dcmo_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   dcmo_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .req_ready (req_ready),
      .start     (start),
      .ctrl      (ctrl)
   );

   dcmo_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .start       (start),
      .req_command (req_chan.command),
      .req_voltage (req_chan.volt_cmd),
      .req_speed   (req_chan.rotor_speed),
      .req_current (req_chan.sensed_current),
      .ctrl        (ctrl),
      .status      (status),
      .rsp_chan    (rsp_chan)
   );

endmodule
